// ===== rtl/sffe_pkg.sv =====
// ----------------------------------------------------------------------------
// sffe_pkg
// Shared types, command ids, field codes and the payload layout table of the
// status frame field extractor.
// ----------------------------------------------------------------------------
package sffe_pkg;

   localparam logic [7:0] START_BYTE = 8'hA5;
   localparam logic [2:0] NO_SLOT    = 3'd7;

   // command ids
   localparam logic [15:0] CMD_STAGE  = 16'd1;
   localparam logic [15:0] CMD_RESULT = 16'd2;
   localparam logic [15:0] CMD_HP     = 16'd3;
   localparam logic [15:0] CMD_AMMO   = 16'd5;
   localparam logic [15:0] CMD_ROBOT  = 16'd201;
   localparam logic [15:0] CMD_WARN   = 16'd260;
   localparam logic [15:0] CMD_POWER  = 16'd514;
   localparam logic [15:0] CMD_BUFF   = 16'd516;
   localparam logic [15:0] CMD_LAUNCH = 16'd519;
   localparam logic [15:0] CMD_REMAIN = 16'd520;

   // field codes
   localparam logic [4:0] F_VOLT      = 5'd0;
   localparam logic [4:0] F_CURRENT   = 5'd1;
   localparam logic [4:0] F_STAGE     = 5'd2;
   localparam logic [4:0] F_TIME      = 5'd3;
   localparam logic [4:0] F_RESULT    = 5'd4;
   localparam logic [4:0] F_HP        = 5'd5;
   localparam logic [4:0] F_MAXHP     = 5'd6;
   localparam logic [4:0] F_LEVEL     = 5'd7;
   localparam logic [4:0] F_AMMO      = 5'd8;
   localparam logic [4:0] F_WARN      = 5'd9;
   localparam logic [4:0] F_FOUL      = 5'd10;
   localparam logic [4:0] F_COOLING   = 5'd11;
   localparam logic [4:0] F_HEAT_LIM  = 5'd12;
   localparam logic [4:0] F_SPEED_LIM = 5'd13;
   localparam logic [4:0] F_POWER_LIM = 5'd14;
   localparam logic [4:0] F_BUFF      = 5'd15;
   localparam logic [4:0] F_FREQ      = 5'd16;
   localparam logic [4:0] F_SPEED     = 5'd17;
   localparam logic [4:0] F_REM_SMALL = 5'd18;
   localparam logic [4:0] F_REM_LARGE = 5'd19;

   typedef enum logic [2:0] {
      K_PLAIN  = 3'd0,
      K_STAGE  = 3'd1,
      K_RESULT = 3'd2,
      K_WARN   = 3'd3,
      K_ROBOT  = 3'd4,
      K_LEVEL  = 3'd5,
      K_RSLOT  = 3'd6,
      K_BUFF   = 3'd7
   } kind_type;

   typedef struct packed {
      logic [15:0] cmd;
      logic [4:0]  off;
      logic [2:0]  len;
      logic [4:0]  code;
      logic [2:0]  slot;
      kind_type    kind;
   } layout_type;

   // one payload byte that belongs to a field
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] rel;
      logic       last;
      logic [4:0] code;
      logic [2:0] slot;
      kind_type   kind;
   } op_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] rel;
      logic       last;
      logic [4:0] code;
      logic [2:0] slot;
      kind_type   kind;
   } desc_type;

   localparam int LAYOUT_COUNT = 36;

   localparam layout_type LAYOUT [LAYOUT_COUNT] = '{
      '{CMD_POWER,  5'd0,  3'd2, F_VOLT,      3'd0, K_PLAIN},
      '{CMD_POWER,  5'd2,  3'd2, F_CURRENT,   3'd0, K_PLAIN},
      '{CMD_STAGE,  5'd0,  3'd1, F_STAGE,     3'd0, K_STAGE},
      '{CMD_STAGE,  5'd1,  3'd2, F_TIME,      3'd0, K_PLAIN},
      '{CMD_RESULT, 5'd0,  3'd1, F_RESULT,    3'd0, K_RESULT},
      '{CMD_HP,     5'd0,  3'd2, F_HP,        3'd0, K_PLAIN},
      '{CMD_HP,     5'd4,  3'd2, F_HP,        3'd1, K_PLAIN},
      '{CMD_HP,     5'd10, 3'd2, F_HP,        3'd2, K_PLAIN},
      '{CMD_HP,     5'd16, 3'd2, F_HP,        3'd3, K_PLAIN},
      '{CMD_HP,     5'd20, 3'd2, F_HP,        3'd4, K_PLAIN},
      '{CMD_HP,     5'd26, 3'd2, F_HP,        3'd5, K_PLAIN},
      '{CMD_AMMO,   5'd3,  3'd2, F_AMMO,      3'd0, K_PLAIN},
      '{CMD_AMMO,   5'd5,  3'd2, F_AMMO,      3'd1, K_PLAIN},
      '{CMD_AMMO,   5'd7,  3'd2, F_AMMO,      3'd2, K_PLAIN},
      '{CMD_AMMO,   5'd9,  3'd2, F_AMMO,      3'd3, K_PLAIN},
      '{CMD_WARN,   5'd0,  3'd1, F_WARN,      3'd0, K_WARN},
      '{CMD_WARN,   5'd1,  3'd1, F_FOUL,      3'd0, K_PLAIN},
      '{CMD_ROBOT,  5'd0,  3'd1, F_VOLT,      3'd0, K_ROBOT},
      '{CMD_ROBOT,  5'd1,  3'd1, F_LEVEL,     3'd0, K_LEVEL},
      '{CMD_ROBOT,  5'd2,  3'd2, F_HP,        3'd0, K_RSLOT},
      '{CMD_ROBOT,  5'd4,  3'd2, F_MAXHP,     3'd0, K_RSLOT},
      '{CMD_ROBOT,  5'd6,  3'd2, F_COOLING,   3'd0, K_PLAIN},
      '{CMD_ROBOT,  5'd8,  3'd2, F_HEAT_LIM,  3'd0, K_PLAIN},
      '{CMD_ROBOT,  5'd10, 3'd2, F_SPEED_LIM, 3'd0, K_PLAIN},
      '{CMD_ROBOT,  5'd12, 3'd2, F_COOLING,   3'd1, K_PLAIN},
      '{CMD_ROBOT,  5'd14, 3'd2, F_HEAT_LIM,  3'd1, K_PLAIN},
      '{CMD_ROBOT,  5'd16, 3'd2, F_SPEED_LIM, 3'd1, K_PLAIN},
      '{CMD_ROBOT,  5'd18, 3'd2, F_COOLING,   3'd2, K_PLAIN},
      '{CMD_ROBOT,  5'd20, 3'd2, F_HEAT_LIM,  3'd2, K_PLAIN},
      '{CMD_ROBOT,  5'd22, 3'd2, F_SPEED_LIM, 3'd2, K_PLAIN},
      '{CMD_ROBOT,  5'd24, 3'd2, F_POWER_LIM, 3'd0, K_PLAIN},
      '{CMD_BUFF,   5'd0,  3'd1, F_BUFF,      3'd0, K_BUFF},
      '{CMD_LAUNCH, 5'd2,  3'd1, F_FREQ,      3'd0, K_PLAIN},
      '{CMD_LAUNCH, 5'd3,  3'd4, F_SPEED,     3'd0, K_PLAIN},
      '{CMD_REMAIN, 5'd0,  3'd2, F_REM_SMALL, 3'd0, K_PLAIN},
      '{CMD_REMAIN, 5'd2,  3'd2, F_REM_LARGE, 3'd0, K_PLAIN}
   };

   function automatic logic [5:0] payload_length(logic [15:0] cmd);
      logic [5:0] len;
      unique case (cmd)
         CMD_POWER:  len = 6'd4;
         CMD_STAGE:  len = 6'd3;
         CMD_RESULT: len = 6'd1;
         CMD_HP:     len = 6'd28;
         CMD_AMMO:   len = 6'd11;
         CMD_WARN:   len = 6'd2;
         CMD_ROBOT:  len = 6'd26;
         CMD_BUFF:   len = 6'd1;
         CMD_LAUNCH: len = 6'd7;
         CMD_REMAIN: len = 6'd4;
         default:    len = 6'd0;
      endcase
      return len;
   endfunction

   function automatic desc_type field_lookup(logic [15:0] cmd, logic [4:0] pi);
      desc_type   d;
      logic [5:0] p;
      logic [5:0] lo;
      logic [5:0] hi;
      d = '0;
      p = {1'b0, pi};
      for (int i = 0; i < LAYOUT_COUNT; i++) begin
         lo = {1'b0, LAYOUT[i].off};
         hi = lo + {3'b000, LAYOUT[i].len};
         if (LAYOUT[i].cmd == cmd && p >= lo && p < hi) begin
            d.hit  = 1'b1;
            d.rel  = 2'(p - lo);
            d.last = (p == hi - 6'd1);
            d.code = LAYOUT[i].code;
            d.slot = LAYOUT[i].slot;
            d.kind = LAYOUT[i].kind;
         end
      end
      return d;
   endfunction

endpackage

// ===== rtl/sffe_front.sv =====
// ----------------------------------------------------------------------------
// sffe_front
// Frame parser: hunts for the start byte, skips the header, takes the
// command id and tags every payload byte that belongs to a known field.
// ----------------------------------------------------------------------------
module sffe_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [7:0]      in_byte,
   input  logic            q_full,
   output logic            q_push,
   output sffe_pkg::op_type q_op
);
   import sffe_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT = 3'b001,
      PH_HEAD = 3'b010,
      PH_LOAD = 3'b100
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hidx_ff, hidx_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [4:0]  pidx_ff, pidx_in;
   logic        take;
   desc_type    desc;
   logic [5:0]  pnext;

   assign in_ready = !q_full;
   assign take     = in_valid && in_ready;
   assign desc     = field_lookup(cmd_ff, pidx_ff);
   assign pnext    = {1'b0, pidx_ff} + 6'd1;

   assign q_op.data = in_byte;
   assign q_op.rel  = desc.rel;
   assign q_op.last = desc.last;
   assign q_op.code = desc.code;
   assign q_op.slot = desc.slot;
   assign q_op.kind = desc.kind;
   assign q_push    = take && (phase_ff == PH_LOAD) && desc.hit;

   always_comb begin
      phase_in = phase_ff;
      hidx_in  = hidx_ff;
      cmd_in   = cmd_ff;
      pidx_in  = pidx_ff;
      if (take) begin
         unique case (phase_ff)
            PH_HEAD: begin
               if (hidx_ff == 3'd4) begin
                  cmd_in = {8'h00, in_byte};
               end else if (hidx_ff == 3'd5) begin
                  cmd_in = {in_byte, cmd_ff[7:0]};
               end
               if (hidx_ff >= 3'd5) begin
                  hidx_in  = 3'd0;
                  pidx_in  = 5'd0;
                  phase_in = (payload_length(cmd_in) != 6'd0) ? PH_LOAD : PH_HUNT;
               end else begin
                  hidx_in = hidx_ff + 3'd1;
               end
            end
            PH_LOAD: begin
               if (pnext >= payload_length(cmd_ff)) begin
                  phase_in = PH_HUNT;
                  pidx_in  = 5'd0;
               end else begin
                  pidx_in = pnext[4:0];
               end
            end
            default: begin
               phase_in = PH_HUNT;
               if (in_byte == START_BYTE) begin
                  phase_in = PH_HEAD;
                  hidx_in  = 3'd0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         hidx_ff  <= 3'd0;
         cmd_ff   <= 16'd0;
         pidx_ff  <= 5'd0;
      end else begin
         phase_ff <= phase_in;
         hidx_ff  <= hidx_in;
         cmd_ff   <= cmd_in;
         pidx_ff  <= pidx_in;
      end
   end

endmodule

// ===== rtl/sffe_queue.sv =====
// ----------------------------------------------------------------------------
// sffe_queue
// Short first-in first-out queue of tagged field beats between the parser
// and the field assembler.
// ----------------------------------------------------------------------------
module sffe_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sffe_pkg::op_type push_op,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output sffe_pkg::op_type pop_op
);
   import sffe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]   wptr_ff, wptr_in;
   logic [PTR_W-1:0]   rptr_ff, rptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign valid   = (cnt_ff != '0);
   assign pop_op  = mem_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ===== rtl/sffe_back.sv =====
// ----------------------------------------------------------------------------
// sffe_back
// Field assembler: gathers field bytes into a value, checks legal codes,
// maps robot ids to slots and holds the finished update in the output
// register.
// ----------------------------------------------------------------------------
module sffe_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  sffe_pkg::op_type q_op,
   output logic             q_pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [4:0]       out_code,
   output logic [2:0]       out_slot,
   output logic [31:0]      out_value
);
   import sffe_pkg::*;

   function automatic logic [2:0] map_robot(logic [31:0] id);
      logic [2:0] s;
      unique case (id)
         32'd1:   s = 3'd0;
         32'd3:   s = 3'd1;
         32'd7:   s = 3'd2;
         32'd101: s = 3'd3;
         32'd103: s = 3'd4;
         32'd107: s = 3'd5;
         default: s = NO_SLOT;
      endcase
      return s;
   endfunction

   logic [31:0] acc_ff, acc_in;
   logic [2:0]  rslot_ff, rslot_in;
   logic        vld_ff, vld_in;
   logic [4:0]  code_ff, code_in;
   logic [2:0]  slot_ff, slot_in;
   logic [31:0] val_ff, val_in;
   logic [31:0] shifted;
   logic [31:0] value;
   logic [31:0] fval;
   logic [2:0]  fslot;
   logic        emit;

   assign q_pop   = q_valid && (!vld_ff || out_ready);
   assign shifted = {24'h000000, q_op.data} << {q_op.rel, 3'b000};
   assign value   = (q_op.rel == 2'd0) ? {24'h000000, q_op.data} : (acc_ff | shifted);

   always_comb begin
      emit     = 1'b0;
      fval     = value;
      fslot    = q_op.slot;
      rslot_in = rslot_ff;
      if (q_op.last) begin
         unique case (q_op.kind)
            K_STAGE: begin
               fval = value >> 4;
               emit = (fval <= 32'd5);
            end
            K_RESULT: emit = (value <= 32'd2);
            K_WARN:   emit = (value >= 32'd1) && (value <= 32'd3);
            K_ROBOT:  rslot_in = map_robot(value);
            K_LEVEL: begin
               fslot = rslot_ff;
               emit  = (rslot_ff != NO_SLOT) && (value >= 32'd1) && (value <= 32'd3);
            end
            K_RSLOT: begin
               fslot = rslot_ff;
               emit  = (rslot_ff != NO_SLOT);
            end
            K_BUFF: begin
               emit = 1'b1;
               priority if (value[0]) begin
                  fval = 32'd0;
               end else if (value[1]) begin
                  fval = 32'd1;
               end else if (value[2]) begin
                  fval = 32'd2;
               end else if (value[3]) begin
                  fval = 32'd3;
               end else begin
                  emit = 1'b0;
               end
            end
            default: emit = 1'b1;
         endcase
      end
   end

   always_comb begin
      acc_in  = acc_ff;
      vld_in  = vld_ff && !out_ready;
      code_in = code_ff;
      slot_in = slot_ff;
      val_in  = val_ff;
      if (q_pop) begin
         acc_in = value;
         vld_in = emit;
         if (emit) begin
            code_in = q_op.code;
            slot_in = fslot;
            val_in  = fval;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= 32'd0;
         rslot_ff <= NO_SLOT;
         vld_ff   <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         rslot_ff <= q_pop ? rslot_in : rslot_ff;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      slot_ff <= slot_in;
      val_ff  <= val_in;
   end

   assign out_valid = vld_ff;
   assign out_code  = code_ff;
   assign out_slot  = slot_ff;
   assign out_value = val_ff;

endmodule

// ===== rtl/status_frame_field_extractor_core.sv =====
// ----------------------------------------------------------------------------
// status_frame_field_extractor_core
// Pulls field updates out of the status serial byte stream.
// ----------------------------------------------------------------------------
// req channel: one received byte per beat (req_rx_byte).
// rsp channel: one field update per beat (rsp_field_code, rsp_slot,
//   rsp_field_value); header, skipped and tail bytes give no beat, nor do
//   illegal codes or fields of an unknown robot.
// The parser takes one byte per cycle while the queue is not full and
//   pushes each field byte into a QUEUE_DEPTH entry queue; the assembler
//   drains one entry per cycle into the output register while it is free.
// Path: the last byte of a field is written into the queue, and the update
//   into the output register before rsp shows it. Throughput: one byte per
//   cycle while rsp_ready is high. Stall: when rsp_ready is low the output
//   register holds, the queue fills and req_ready drops once it is full;
//   bytes outside fields are still refused then.
// Reset: the parser hunts for the start byte, the queue is empty, the
//   accumulator is zero and the robot slot is invalid.
// ----------------------------------------------------------------------------
module status_frame_field_extractor_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_field_code,
   output logic [2:0]  rsp_slot,
   output logic [31:0] rsp_field_value
);
   import sffe_pkg::*;

   logic   push;
   op_type push_op;
   logic   full;
   logic   pop;
   logic   q_valid;
   op_type pop_op;

   sffe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_byte  (req_rx_byte),
      .q_full   (full),
      .q_push   (push),
      .q_op     (push_op)
   );

   sffe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (full),
      .pop     (pop),
      .valid   (q_valid),
      .pop_op  (pop_op)
   );

   sffe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_op      (pop_op),
      .q_pop     (pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_code  (rsp_field_code),
      .out_slot  (rsp_slot),
      .out_value (rsp_field_value)
   );

endmodule
